/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL. Each use stands on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define AST_PROP(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// An antecedent that must be followed in the same cycle by its consequent.
`define AST_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/core/rtcm_pkg.sv */
`timescale 1ns / 1ps

package rtcm_pkg;

  // Slots for fragment lengths and sequence ids; the fragment id field is two bits.
  localparam int FRAG_SLOTS = 4;

  localparam logic [7:0] POS_MAX = 8'hFF;

  typedef logic [FRAG_SLOTS-1:0][7:0] len_arr_t;
  typedef logic [FRAG_SLOTS-1:0][4:0] seq_arr_t;

  // One result travelling from the accept stage toward the output register.
  typedef struct packed {
    logic       has;
    logic       use_mem;
    logic [7:0] byte_val;
    logic       last;
    logic       dropped;
  } result_t;

  // First slot at or after from, up to lfi, that holds bytes. Bit 2 set means none.
  function automatic logic [2:0] next_filled(input logic [2:0] from,
                                             input logic [1:0] lfi,
                                             input len_arr_t   lens);
    logic [2:0] found;
    found = 3'd4;
    for (int i = FRAG_SLOTS - 1; i >= 0; i--) begin
      if (3'(i) >= from && 2'(i) <= lfi && lens[i] != 8'd0) begin
        found = 3'(i);
      end
    end
    return found;
  endfunction

endpackage

/* rtl/core/rtcm_fragment_reassembler.sv */
`timescale 1ns / 1ps

// Channel  Handshake            Payload
// in       in_valid / in_stall  kind, msg_flags, msg_len, data_byte, byte_last
// out      out_valid / out_stall out_byte, out_last, dropped
//
// One item per cycle unless stalled; a result is held in stage one, then in the output.
// All bookkeeping is in registers, and the fragment store has one write and one
// read port; each item touches at most one store entry, which sets the rate.
// Reset clears control state only; the store is not cleared.
// A stall on out backs up through one held result into in_stall in the same cycle.

`include "assert_macros.svh"

module rtcm_fragment_reassembler #(
  parameter int FRAGMENT_BYTES = 180,
  parameter int FRAGMENT_COUNT = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       kind,
  input  logic [7:0] msg_flags,
  input  logic [7:0] msg_len,
  input  logic [7:0] data_byte,
  input  logic       byte_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       dropped
);

  localparam int         DEPTH = FRAGMENT_COUNT * FRAGMENT_BYTES;
  localparam int         AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [7:0] FB8   = 8'(FRAGMENT_BYTES);
  localparam logic [2:0] FC3   = 3'(FRAGMENT_COUNT);

  logic [7:0] store [DEPTH];
  logic [7:0] rdata;

  rtcm_pkg::len_arr_t frag_len, frag_len_next;
  rtcm_pkg::seq_arr_t frag_seq, frag_seq_next;
  logic [1:0]         last_idx, last_idx_next;
  logic [7:0]         byte_pos, byte_pos_next;
  logic               drain_pending, drain_pending_next;
  logic [1:0]         drain_frag, drain_frag_next;
  logic [7:0]         drain_pos, drain_pos_next;

  rtcm_pkg::result_t res;
  logic              can_load;
  logic              accept;
  logic              ld;
  logic              wr_en;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;

  logic [2:0] fill_f;
  logic [2:0] fill_g;
  logic [7:0] flen;
  logic [7:0] dpos;
  logic [7:0] dpos_inc;
  logic [1:0] fid;
  logic [4:0] seq;
  logic       fid_ok;
  logic [7:0] cap;
  logic [7:0] pos_inc;
  logic [1:0] lfi_new;
  logic       same;

  assign in_stall = !can_load;
  assign accept   = in_valid && can_load;
  assign ld       = accept && res.has;

  always_comb begin
    frag_len_next      = frag_len;
    frag_seq_next      = frag_seq;
    last_idx_next      = last_idx;
    byte_pos_next      = byte_pos;
    drain_pending_next = drain_pending;
    drain_frag_next    = drain_frag;
    drain_pos_next     = drain_pos;
    res                = '0;
    wr_en              = 1'b0;
    waddr              = '0;
    raddr              = '0;
    fill_g             = 3'd4;
    flen               = 8'd0;
    dpos               = 8'd0;
    dpos_inc           = 8'd0;
    lfi_new            = last_idx;
    same               = 1'b1;

    fid     = msg_flags[2:1];
    seq     = msg_flags[7:3];
    fid_ok  = {1'b0, fid} < FC3;
    cap     = (msg_len < FB8) ? msg_len : FB8;
    pos_inc = (byte_pos != rtcm_pkg::POS_MAX) ? byte_pos + 8'd1 : byte_pos;
    fill_f  = rtcm_pkg::next_filled({1'b0, drain_frag}, last_idx, frag_len);

    if (kind) begin
      if (drain_pending) begin
        if (fill_f[2]) begin
          // Every remaining fragment is empty: the drain ends without a result.
          drain_pending_next = 1'b0;
          drain_frag_next    = 2'd0;
          drain_pos_next     = 8'd0;
          last_idx_next      = 2'd0;
        end else begin
          flen        = frag_len[fill_f[1:0]];
          dpos        = (drain_pos >= flen) ? 8'd0 : drain_pos;
          dpos_inc    = dpos + 8'd1;
          raddr       = AW'(fill_f[1:0]) * AW'(FRAGMENT_BYTES) + AW'(dpos);
          res.has     = 1'b1;
          res.use_mem = 1'b1;
          if (dpos_inc >= flen) begin
            fill_g = rtcm_pkg::next_filled({1'b0, fill_f[1:0]} + 3'd1, last_idx, frag_len);
            if (fill_g[2]) begin
              res.last           = 1'b1;
              drain_pending_next = 1'b0;
              drain_frag_next    = 2'd0;
              drain_pos_next     = 8'd0;
              last_idx_next      = 2'd0;
            end else begin
              drain_frag_next = fill_g[1:0];
              drain_pos_next  = 8'd0;
            end
          end else begin
            drain_frag_next = fill_f[1:0];
            drain_pos_next  = dpos_inc;
          end
        end
      end
    end else if (drain_pending) begin
      res.has     = 1'b1;
      res.dropped = 1'b1;
    end else if (!msg_flags[0]) begin
      res.has      = 1'b1;
      res.byte_val = data_byte;
      res.last     = byte_last;
    end else begin
      wr_en = fid_ok && (byte_pos < cap);
      waddr = AW'(fid) * AW'(FRAGMENT_BYTES) + AW'(byte_pos);
      if (!byte_last) begin
        byte_pos_next = pos_inc;
      end else begin
        byte_pos_next = 8'd0;
        if (fid_ok) begin
          lfi_new            = (msg_len < FB8) ? fid : last_idx;
          last_idx_next      = lfi_new;
          frag_seq_next[fid] = seq;
          frag_len_next[fid] = (pos_inc < cap) ? pos_inc : cap;
          // Complete if last index > 0 and all fragments below it carry this seq id.
          for (int i = 0; i < rtcm_pkg::FRAG_SLOTS; i++) begin
            if (2'(i) < lfi_new && frag_seq_next[i] != seq) begin
              same = 1'b0;
            end
          end
          if (lfi_new != 2'd0 && same) begin
            drain_pending_next = 1'b1;
            drain_frag_next    = 2'd0;
            drain_pos_next     = 8'd0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frag_len      <= '0;
      frag_seq      <= '0;
      last_idx      <= 2'd0;
      byte_pos      <= 8'd0;
      drain_pending <= 1'b0;
      drain_frag    <= 2'd0;
      drain_pos     <= 8'd0;
    end else if (accept) begin
      frag_len      <= frag_len_next;
      frag_seq      <= frag_seq_next;
      last_idx      <= last_idx_next;
      byte_pos      <= byte_pos_next;
      drain_pending <= drain_pending_next;
      drain_frag    <= drain_frag_next;
      drain_pos     <= drain_pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      store[waddr] <= data_byte;
    end
  end

  // A write is visible to a read issued at any later edge, not to one at the same edge.
  always_ff @(posedge clk) begin
    if (ld && res.use_mem) begin
      rdata <= store[raddr];
    end
  end

  rtcm_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .ld        (ld),
    .res       (res),
    .rdata     (rdata),
    .out_stall (out_stall),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .dropped   (dropped)
  );

  `AST_IMPLY(a_drain_has_last, drain_pending, last_idx != 2'd0)
  `AST_IMPLY(a_drain_from_frag, $rose(drain_pending), $past(accept && !kind && msg_flags[0]))
  `AST_IMPLY(a_drop_shape, out_valid && dropped, out_byte == 8'd0 && !out_last)
  `AST_PROP(a_no_write_in_drain, !(drain_pending && accept && wr_en))

endmodule

/* rtl/core/rtcm_out_stage.sv */
`timescale 1ns / 1ps

module rtcm_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              ld,
  input  rtcm_pkg::result_t res,
  input  logic [7:0]        rdata,
  input  logic              out_stall,
  output logic              can_load,
  output logic              out_valid,
  output logic [7:0]        out_byte,
  output logic              out_last,
  output logic              dropped
);

  logic              s1_valid;
  rtcm_pkg::result_t s1_res;
  logic              s1_move;

  // The stage-one item moves on when the output register is empty or being taken.
  assign s1_move  = s1_valid && (!out_valid || !out_stall);
  assign can_load = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (can_load) begin
      s1_valid <= ld;
    end
  end

  always_ff @(posedge clk) begin
    if (ld && can_load) begin
      s1_res <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Store data is registered when the item is accepted and held while stage one waits.
  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_byte <= s1_res.use_mem ? rdata : s1_res.byte_val;
      out_last <= s1_res.last;
      dropped  <= s1_res.dropped;
    end
  end

endmodule
